/* design/imts_pkg.sv */
// package for the i2c master transaction sequencer
// holds command and status codes and the transaction payload structs; no dependencies
`default_nettype none

package imts_pkg;

   // bus event and request codes carried in the command field
   typedef enum logic [2:0] {
      CMD_LOAD       = 3'd0,
      CMD_BEGIN      = 3'd1,
      CMD_START_SENT = 3'd2,
      CMD_ADDR_DONE  = 3'd3,
      CMD_TX_EMPTY   = 3'd4,
      CMD_RX_BYTE    = 3'd5,
      CMD_ABORT      = 3'd6
   } cmd_type;

   // transaction status codes
   typedef enum logic [2:0] {
      ST_WR_FAIL    = 3'd0,
      ST_RD_FAIL    = 3'd1,
      ST_XF_FAIL_WR = 3'd2,
      ST_XF_FAIL_RD = 3'd3,
      ST_WR_OK      = 3'd4,
      ST_RD_OK      = 3'd5,
      ST_XF_OK      = 3'd6
   } status_type;

   // configuration register indexes
   localparam logic CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic CSR_READ_LENGTH   = 1'b1;

   // largest read; longer read lengths saturate to it
   localparam int unsigned READ_DEPTH = 16;

   localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
   localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data;
      logic       tx_complete;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       gen_start;
      logic       gen_stop;
      logic       ack_enable;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_res;
      logic [2:0] status;
      logic       busy_res;
      logic [4:0] bytes_written;
   } rsp_type;

endpackage

`default_nettype wire

/* design/i2c_master_transaction_sequencer.sv */
// top level of the i2c master transaction sequencer
// uses imts_pkg, imts_core (with imts_ram) and imts_out_fifo
//
// req channel: one transaction per command (load byte, begin, bus event,
// abort); each accepted transaction yields exactly one rsp transaction with
// the bus action, any received byte, done flag and status.
// csr channel: always ready; index 0 slave address, index 1 read length.
// writes arriving while a bus transaction is open are dropped.
// a result is registered into the buffer and is visible on rsp in the cycle
// after its request is taken when no earlier result is still waiting there.
// throughput: one request per cycle while req_ready is high; the decode is
// combinational and the write store is read ahead through its registered port.
// a two-entry result buffer keeps req_ready high while one result waits;
// req_ready drops whenever both entries are full, also in a cycle where
// rsp_ready takes one, so a full buffer stalls the request channel.
// reset (synchronous): no transaction open, write store empty, status wr
// fail, both configuration registers zero, result buffer empty.
`default_nettype none

module i2c_master_transaction_sequencer #(
   parameter int WRITE_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire imts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output imts_pkg::rsp_type rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [7:0]   csr_data
);

   imts_pkg::rsp_type core_rsp;
   logic              req_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   imts_core #(
      .WRITE_DEPTH(WRITE_DEPTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req      (req_data),
      .csr_fire (csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .rsp      (core_rsp)
   );

   imts_out_fifo u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_data  (core_rsp),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data (rsp_data)
   );

endmodule

`default_nettype wire

/* design/imts_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module imts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/imts_core.sv */
// sequencing logic: transaction state, configuration registers, write store
// and the combinational decode of each transaction into its result; uses imts_pkg, imts_ram
`default_nettype none

module imts_core #(
   parameter int WRITE_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_fire,
   input  wire imts_pkg::req_type req,
   input  wire logic             csr_fire,
   input  wire logic             csr_index,
   input  wire logic [7:0]       csr_data,
   output imts_pkg::rsp_type     rsp
);

   localparam int FW = $clog2(WRITE_DEPTH + 1);
   localparam int AW = WRITE_DEPTH > 1 ? $clog2(WRITE_DEPTH) : 1;

   logic [FW-1:0] write_fill_ff, write_fill_in;
   logic [FW-1:0] write_pos_ff, write_pos_in;
   logic [4:0]    read_count_ff, read_count_in;
   logic          reading_ff, reading_in;
   logic [2:0]    status_ff, status_in;
   logic          active_ff, active_in;
   logic [7:0]    slave_address_ff, slave_address_in;
   logic [4:0]    read_length_ff, read_length_in;

   logic [4:0]    read_target;
   logic [4:0]    read_count_inc;
   logic          store_wr;
   logic [7:0]    store_rd_data;

   // read address follows the next write position so the byte is ready in the cycle after
   imts_ram #(
      .WIDTH(8),
      .DEPTH(WRITE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (store_wr),
      .wr_addr(write_fill_ff[AW-1:0]),
      .wr_data(req.data),
      .rd_addr(write_pos_in[AW-1:0]),
      .rd_data(store_rd_data)
   );

   assign read_target = (read_length_ff > 5'(imts_pkg::READ_DEPTH))
                        ? 5'(imts_pkg::READ_DEPTH) : read_length_ff;
   assign read_count_inc = read_count_ff + ((read_count_ff < read_target) ? 5'd1 : 5'd0);
   assign store_wr = req_fire && (req.command == imts_pkg::CMD_LOAD) && !active_ff
                     && (write_fill_ff < FW'(WRITE_DEPTH));

   // configuration writes are dropped while a transaction is open
   always_comb begin
      slave_address_in = slave_address_ff;
      read_length_in   = read_length_ff;
      if (csr_fire && !active_ff) begin
         unique case (csr_index)
            imts_pkg::CSR_SLAVE_ADDRESS: slave_address_in = csr_data;
            imts_pkg::CSR_READ_LENGTH:   read_length_in   = csr_data[4:0];
            default:                     slave_address_in = slave_address_ff;
         endcase
      end
   end

   always_comb begin
      write_fill_in = write_fill_ff;
      write_pos_in  = write_pos_ff;
      read_count_in = read_count_ff;
      reading_in    = reading_ff;
      status_in     = status_ff;
      active_in     = active_ff;
      rsp           = '0;
      if (req_fire) begin
         unique case (req.command)
            imts_pkg::CMD_LOAD: begin
               if (store_wr) begin
                  write_fill_in = write_fill_ff + FW'(1);
               end
            end
            imts_pkg::CMD_BEGIN: begin
               if (!active_ff) begin
                  if (write_fill_ff != '0 || read_target != '0) begin
                     if (write_fill_ff != '0 && read_target != '0) begin
                        status_in = imts_pkg::ST_XF_FAIL_WR;
                     end else if (write_fill_ff != '0) begin
                        status_in = imts_pkg::ST_WR_FAIL;
                     end else begin
                        status_in = imts_pkg::ST_RD_FAIL;
                     end
                     reading_in     = (write_fill_ff == '0);
                     active_in      = 1'b1;
                     write_pos_in   = '0;
                     read_count_in  = '0;
                     rsp.gen_start  = 1'b1;
                  end else begin
                     // nothing to send or receive: refuse
                     status_in    = imts_pkg::ST_WR_FAIL;
                     rsp.gen_stop = 1'b1;
                     rsp.done_res = 1'b1;
                  end
               end
            end
            imts_pkg::CMD_START_SENT: begin
               if (active_ff) begin
                  rsp.tx_valid = 1'b1;
                  rsp.tx_byte  = reading_ff ? (slave_address_ff | imts_pkg::ADDR_READ_BIT)
                                            : (slave_address_ff & imts_pkg::ADDR_WRITE_MASK);
               end
            end
            imts_pkg::CMD_ADDR_DONE: begin
               if (active_ff && reading_ff) begin
                  // single-byte read: no ack and the stop goes out right away
                  if (read_target > 5'd1) begin
                     rsp.ack_enable = 1'b1;
                  end else begin
                     rsp.gen_stop = 1'b1;
                  end
               end
            end
            imts_pkg::CMD_TX_EMPTY: begin
               if (active_ff && !reading_ff) begin
                  if (write_pos_ff < write_fill_ff) begin
                     rsp.tx_valid = 1'b1;
                     rsp.tx_byte  = store_rd_data;
                     write_pos_in = write_pos_ff + FW'(1);
                  end else if (req.tx_complete) begin
                     if (read_target != '0) begin
                        // repeated start into the read phase
                        status_in     = imts_pkg::ST_XF_FAIL_RD;
                        reading_in    = 1'b1;
                        read_count_in = '0;
                        rsp.gen_start = 1'b1;
                     end else begin
                        status_in     = imts_pkg::ST_WR_OK;
                        rsp.gen_stop  = 1'b1;
                        rsp.done_res  = 1'b1;
                        active_in     = 1'b0;
                        write_fill_in = '0;
                     end
                  end
               end
            end
            imts_pkg::CMD_RX_BYTE: begin
               if (active_ff && reading_ff) begin
                  rsp.rx_valid  = 1'b1;
                  rsp.rx_byte   = req.data;
                  read_count_in = read_count_inc;
                  if (read_target - read_count_inc == 5'd1) begin
                     rsp.gen_stop = 1'b1;
                  end else if (read_count_inc >= read_target) begin
                     status_in     = (status_ff == imts_pkg::ST_XF_FAIL_RD)
                                     ? imts_pkg::ST_XF_OK : imts_pkg::ST_RD_OK;
                     rsp.gen_stop  = 1'b1;
                     rsp.done_res  = 1'b1;
                     active_in     = 1'b0;
                     write_fill_in = '0;
                  end
               end
            end
            imts_pkg::CMD_ABORT: begin
               rsp.gen_stop  = 1'b1;
               rsp.done_res  = 1'b1;
               active_in     = 1'b0;
               write_fill_in = '0;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
      rsp.status        = status_in;
      rsp.busy_res      = active_in;
      rsp.bytes_written = 5'(write_pos_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_fill_ff    <= '0;
         write_pos_ff     <= '0;
         read_count_ff    <= '0;
         reading_ff       <= 1'b0;
         status_ff        <= imts_pkg::ST_WR_FAIL;
         active_ff        <= 1'b0;
         slave_address_ff <= '0;
         read_length_ff   <= '0;
      end else begin
         write_fill_ff    <= write_fill_in;
         write_pos_ff     <= write_pos_in;
         read_count_ff    <= read_count_in;
         reading_ff       <= reading_in;
         status_ff        <= status_in;
         active_ff        <= active_in;
         slave_address_ff <= slave_address_in;
         read_length_ff   <= read_length_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      write_fill_ff <= FW'(WRITE_DEPTH))
      else $error("write store fill beyond depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> write_pos_ff <= write_fill_ff)
      else $error("write position past fill during transaction");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (active_ff && reading_ff) |-> (read_target != '0 && read_count_ff <= read_target))
      else $error("read count out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp.done_res) |=> (!active_ff && write_fill_ff == '0))
      else $error("transaction still open after done");

endmodule

`default_nettype wire

/* design/imts_out_fifo.sv */
// two-entry result buffer between the sequencing logic and the result channel
// uses imts_pkg
`default_nettype none

module imts_out_fifo (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire imts_pkg::rsp_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output imts_pkg::rsp_type out_data
);

   logic [1:0]        count_ff, count_in;
   imts_pkg::rsp_type head_ff, head_in;
   imts_pkg::rsp_type tail_ff, tail_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
      if (pop) begin
         if (count_ff == 2'd2) begin
            head_in = tail_ff;
         end else if (push) begin
            head_in = in_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = in_data;
         end else begin
            tail_in = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire
